@@ rtl/trle_pkg.sv @@
// trle_pkg: shared types and constants of the tga rle pixel decoder
`timescale 1ns / 1ps

package trle_pkg;

  // run-length packet and pixel format
  localparam int unsigned MaxBurst = 64;
  localparam int unsigned BurstW   = $clog2(MaxBurst);
  localparam logic [2:0]  BppRgba  = 3'd4;
  localparam logic [2:0]  BppRgb   = 3'd3;

  // configuration register indexes (paddr bit 2)
  localparam logic RegBpp   = 1'b0;
  localparam logic RegCount = 1'b1;

  // register reset values
  localparam logic [2:0]  BppReset   = 3'd3;
  localparam logic [31:0] CountReset = 32'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEFT,
    S_RUN,
    S_RAW
  } state_e;

  // sequencer to pixel counter
  typedef struct packed {
    logic step;
    logic close;
  } cnt_ctl_t;

  // pixel counter to sequencer
  typedef struct packed {
    logic overrun;
    logic image_end;
  } cnt_stat_t;

endpackage

@@ rtl/trle_byte_if.sv @@
// trle_byte_if: compressed byte stream channel
`timescale 1ns / 1ps

interface trle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

@@ rtl/trle_pix_if.sv @@
// trle_pix_if: decoded pixel channel
`timescale 1ns / 1ps

interface trle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       image_done;
  logic       overrun_error;
  logic       last_of_burst;

  modport source (
    output valid, output red, output green, output blue, output alpha,
    output image_done, output overrun_error, output last_of_burst,
    input ready
  );
  modport sink (
    input valid, input red, input green, input blue, input alpha,
    input image_done, input overrun_error, input last_of_burst,
    output ready
  );
endinterface

@@ rtl/trle_pixcnt.sv @@
// trle_pixcnt: image pixel counter with overrun and image end compare
`timescale 1ns / 1ps

module trle_pixcnt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         count_i,
  input  trle_pkg::cnt_ctl_t  ctl_i,
  output trle_pkg::cnt_stat_t stat_o
);

  logic [31:0] done_q, done_d;
  logic [31:0] done_inc;

  assign done_inc         = done_q + 32'd1;
  assign stat_o.overrun   = (done_q >= count_i);
  // only meaningful when there is no overrun, so no wrap to worry about
  assign stat_o.image_end = (done_inc == count_i);

  always_comb begin
    done_d = done_q;
    if (ctl_i.step) begin
      priority if (stat_o.overrun) begin
        done_d = '0;
      end else if (ctl_i.close && stat_o.image_end) begin
        done_d = '0;
      end else begin
        done_d = done_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else begin
      done_q <= done_d;
    end
  end

endmodule

@@ rtl/tga_rle_pixel_decoder.sv @@
// tga_rle_pixel_decoder: top level of the tga run-length pixel decoder
//
//  channel   dir  handshake       payload
//  in_i      in   valid/ready     stream_byte[7:0]
//  out_o     out  valid/ready     red, green, blue, alpha, image_done,
//                                 overrun_error, last_of_burst
//  apb       in   psel/penable    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// headers and non-final pixel bytes are taken in the idle state
// the byte completing a pixel starts S_RAW, which emits it once, or S_RUN, which emits copies
// (up to 64 per burst), all through the single pixel counter compare unit
// a header following a truncated run first emits the remaining copies
// output stalls hold the sequencer; in_i is not ready while results are pending
// reset is asynchronous active low and clears all control state
`timescale 1ns / 1ps

module tga_rle_pixel_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  trle_byte_if.sink          in_i,
  trle_pix_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned BW = trle_pkg::BurstW;

  // configuration
  logic [2:0]  bpp_q;
  logic [31:0] count_q;
  logic        cfg_wr;

  // sequencer state
  trle_pkg::state_e state_q, state_d;
  logic          exp_hdr_q, exp_hdr_d;
  logic          is_run_q, is_run_d;
  logic [7:0]    left_q, left_d;
  logic [1:0]    idx_q, idx_d;
  logic [31:0]   pix_q, pix_d;
  logic [BW-1:0] burst_q, burst_d;
  logic [7:0]    hdr_q, hdr_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic       done_flag_q, err_flag_q, last_flag_q;

  logic                emit, emit_err, emit_last, emit_ok;
  logic                hdr_load;
  logic [7:0]          hdr_byte;
  logic [2:0]          pix_size;
  trle_pkg::cnt_ctl_t  cnt_ctl;
  trle_pkg::cnt_stat_t cnt_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      trle_pkg::RegBpp:   prdata = {29'd0, bpp_q};
      trle_pkg::RegCount: prdata = count_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= trle_pkg::BppReset;
      count_q <= trle_pkg::CountReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        trle_pkg::RegBpp:   bpp_q <= pwdata[2:0];
        trle_pkg::RegCount: count_q <= pwdata;
        default:            ;
      endcase
    end
  end

  assign pix_size = (bpp_q == trle_pkg::BppRgba) ? trle_pkg::BppRgba : trle_pkg::BppRgb;
  assign emit_ok  = !out_valid_q || out_o.ready;

  trle_pixcnt u_pixcnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .count_i(count_q),
    .ctl_i  (cnt_ctl),
    .stat_o (cnt_stat)
  );

  always_comb begin
    state_d   = state_q;
    exp_hdr_d = exp_hdr_q;
    is_run_d  = is_run_q;
    left_d    = left_q;
    idx_d     = idx_q;
    pix_d     = pix_q;
    burst_d   = burst_q;
    hdr_d     = hdr_q;
    in_i.ready = 1'b0;
    emit      = 1'b0;
    emit_err  = 1'b0;
    emit_last = 1'b0;
    cnt_ctl   = '0;
    hdr_load  = 1'b0;
    hdr_byte  = in_i.stream_byte;

    unique case (state_q)
      trle_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (exp_hdr_q) begin
            if (left_q != 8'd0) begin
              // finish the truncated run before taking this header
              hdr_d   = in_i.stream_byte;
              burst_d = '0;
              state_d = trle_pkg::S_LEFT;
            end else begin
              hdr_load = 1'b1;
            end
          end else begin
            unique case (idx_q)
              2'd0: pix_d[7:0]   = in_i.stream_byte;
              2'd1: pix_d[15:8]  = in_i.stream_byte;
              2'd2: pix_d[23:16] = in_i.stream_byte;
              2'd3: pix_d[31:24] = in_i.stream_byte;
              default: ;
            endcase
            if (({1'b0, idx_q} + 3'd1) >= pix_size) begin
              idx_d   = '0;
              burst_d = '0;
              state_d = is_run_q ? trle_pkg::S_RUN : trle_pkg::S_RAW;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end
      end

      trle_pkg::S_LEFT, trle_pkg::S_RUN: begin
        if (emit_ok) begin
          emit         = 1'b1;
          cnt_ctl.step = 1'b1;
          if (cnt_stat.overrun) begin
            emit_err  = 1'b1;
            emit_last = 1'b1;
            left_d    = '0;
            idx_d     = '0;
            exp_hdr_d = 1'b1;
          end else begin
            left_d  = left_q - 8'd1;
            burst_d = burst_q + BW'(1);
            if (left_q == 8'd1 || burst_q == BW'(trle_pkg::MaxBurst - 1)) begin
              emit_last     = 1'b1;
              exp_hdr_d     = 1'b1;
              cnt_ctl.close = (left_q == 8'd1);
            end
          end
          if (emit_last) begin
            state_d = trle_pkg::S_IDLE;
            if (state_q == trle_pkg::S_LEFT) begin
              hdr_load = 1'b1;
              hdr_byte = hdr_q;
            end
          end
        end
      end

      trle_pkg::S_RAW: begin
        if (emit_ok) begin
          emit         = 1'b1;
          emit_last    = 1'b1;
          cnt_ctl.step = 1'b1;
          state_d      = trle_pkg::S_IDLE;
          if (cnt_stat.overrun) begin
            emit_err  = 1'b1;
            left_d    = '0;
            idx_d     = '0;
            exp_hdr_d = 1'b1;
          end else begin
            left_d = left_q - 8'd1;
            if (left_q == 8'd1) begin
              exp_hdr_d     = 1'b1;
              cnt_ctl.close = 1'b1;
            end
          end
        end
      end

      default: state_d = trle_pkg::S_IDLE;
    endcase

    // header: below 128 gives b+1 raw pixels, else b-127 run copies
    if (hdr_load) begin
      exp_hdr_d = 1'b0;
      idx_d     = '0;
      pix_d     = '0;
      is_run_d  = hdr_byte[7];
      left_d    = {1'b0, hdr_byte[6:0]} + 8'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trle_pkg::S_IDLE;
      exp_hdr_q   <= 1'b1;
      is_run_q    <= 1'b0;
      left_q      <= '0;
      idx_q       <= '0;
      pix_q       <= '0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_hdr_q   <= exp_hdr_d;
      is_run_q    <= is_run_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      pix_q       <= pix_d;
      burst_q     <= burst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (emit) begin
      red_q       <= emit_err ? 8'd0 : pix_q[23:16];
      green_q     <= emit_err ? 8'd0 : pix_q[15:8];
      blue_q      <= emit_err ? 8'd0 : pix_q[7:0];
      alpha_q     <= (!emit_err && bpp_q == trle_pkg::BppRgba) ? pix_q[31:24] : 8'd0;
      done_flag_q <= !emit_err && cnt_stat.image_end;
      err_flag_q  <= emit_err;
      last_flag_q <= emit_last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.red           = red_q;
  assign out_o.green         = green_q;
  assign out_o.blue          = blue_q;
  assign out_o.alpha         = alpha_q;
  assign out_o.image_done    = done_flag_q;
  assign out_o.overrun_error = err_flag_q;
  assign out_o.last_of_burst = last_flag_q;

  // an error transaction carries no pixel and closes the burst
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overrun_error |->
      out_o.red == 8'd0 && out_o.green == 8'd0 && out_o.blue == 8'd0 &&
      out_o.alpha == 8'd0 && !out_o.image_done && out_o.last_of_burst)
    else $error("error transaction carries pixel data");

  // emit states never run with an empty packet
  a_copy_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trle_pkg::S_RUN || state_q == trle_pkg::S_LEFT ||
     state_q == trle_pkg::S_RAW) |-> left_q != 8'd0)
    else $error("emit state with no pixels left in packet");

  // a header byte taken while run copies are owed moves to S_LEFT
  a_no_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> $past(!exp_hdr_q || left_q == 8'd0) ||
      state_q == trle_pkg::S_LEFT)
    else $error("byte taken with run copies pending");

  // a stalled result is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !emit)
    else $error("result overwritten while stalled");

endmodule
